/* hw/rtl/szd_pkg.sv */
// ----------------------------------------------------------------------------
// szd_pkg : shared types and constants of the smoothed z-score peak detector
// Register map, field widths of the configuration registers and defaults.
// ----------------------------------------------------------------------------
package szd_pkg;

    // default build parameters
    localparam int SZD_MAX_LAG     = 32;
    localparam int SZD_SAMPLE_BITS = 16;
    localparam int SZD_INDEX_BITS  = 16;

    // configuration register widths
    localparam int SZD_WL_W    = 6;
    localparam int SZD_THR_W   = 16;
    localparam int SZD_WGT_W   = 17;
    localparam int SZD_FLOOR_W = 16;

    localparam int SZD_CFG_IDX_W  = 2;
    localparam int SZD_CFG_DATA_W = 17;

    // fixed-point positions
    localparam int SZD_THR_FRAC = 8;   // threshold is Q8.8
    localparam int SZD_WGT_FRAC = 16;  // weight is Q1.16

    localparam logic [SZD_WGT_W-1:0] SZD_WGT_ONE = 17'h10000;

    // digit width of the shared multiplier
    localparam int SZD_MUL_DIG = 16;

    // reset values
    localparam logic [SZD_WL_W-1:0]    SZD_WL_RST    = 6'd20;
    localparam logic [SZD_THR_W-1:0]   SZD_THR_RST   = 16'd4800;
    localparam logic [SZD_WGT_W-1:0]   SZD_WGT_RST   = 17'd3277;
    localparam logic [SZD_FLOOR_W-1:0] SZD_FLOOR_RST = 16'd6636;

    typedef enum logic [SZD_CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH     = 2'd0,
        REG_THRESHOLD_SQUARED = 2'd1,
        REG_INFLUENCE_WEIGHT  = 2'd2,
        REG_FLOOR_LEVEL       = 2'd3
    } cfg_reg_e_t;

    typedef struct packed {
        logic [SZD_WL_W-1:0]    window_length;
        logic [SZD_THR_W-1:0]   threshold_squared;
        logic [SZD_WGT_W-1:0]   influence_weight;
        logic [SZD_FLOOR_W-1:0] floor_level;      // two's complement Q1.14
    } cfg_t;

endpackage

/* hw/rtl/szd_mul.sv */
// ----------------------------------------------------------------------------
// szd_mul : shared digit-serial multiplier
// Signed A times unsigned B, one DIG-bit digit of B per cycle, MSB first.
// ----------------------------------------------------------------------------
module szd_mul #(
    parameter int PA  = 51,
    parameter int PB  = 32,
    parameter int DIG = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [PA-1:0]     a,
    input  logic        [PB-1:0]     b,
    output logic                     done,
    output logic signed [PA+PB-1:0]  p
);

    localparam int PW    = PA + PB;
    localparam int STEPS = PB / DIG;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic signed [PA-1:0]    a_reg;
    logic        [PB-1:0]    b_reg;
    logic signed [PW-1:0]    acc_reg;
    logic        [CNT_W-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic        [DIG-1:0]   dig;
    logic signed [PA+DIG:0]  prod;
    logic signed [PW-1:0]    acc_next;

    assign dig      = b_reg[PB-1 -: DIG];
    assign prod     = a_reg * $signed({1'b0, dig});
    assign acc_next = (acc_reg <<< DIG) + PW'(prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operand and accumulator registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << DIG;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

/* hw/rtl/szd_seq.sv */
// ----------------------------------------------------------------------------
// szd_seq : sequencer, history memory and result register
// Walks one sample through judge, blend and window sums on the shared unit.
// ----------------------------------------------------------------------------
module szd_seq #(
    parameter int MAX_LAG     = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  szd_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [INDEX_BITS-1:0]         out_index,
    output logic                          out_peak,
    output logic                          out_outlier,
    output logic                          out_last
);

    import szd_pkg::*;

    localparam int SW     = SAMPLE_BITS;
    localparam int IB     = INDEX_BITS;
    localparam int LW     = $clog2(MAX_LAG + 1);
    localparam int HD     = MAX_LAG + 1;
    localparam int AW     = $clog2(HD);
    localparam int SUM_W  = SW + LW;
    localparam int SQ_W   = 2 * SW + LW;
    localparam int V_W    = 2 * SUM_W;
    localparam int VL_W   = V_W + LW;
    localparam int RT_W   = VL_W + SZD_THR_W;
    localparam int LF_W   = 2 * SUM_W + LW + SZD_THR_FRAC;
    localparam int PA     = VL_W + 1;
    localparam int PB_RAW = (SUM_W > SZD_WGT_W) ? SUM_W : SZD_WGT_W;
    localparam int PB     = ((PB_RAW + SZD_MUL_DIG - 1) / SZD_MUL_DIG) * SZD_MUL_DIG;
    localparam int PW     = PA + PB;
    localparam int BL_W   = SW + SZD_WGT_W + 1;
    localparam int Q_W    = BL_W - SZD_WGT_FRAC;
    localparam int LC_W   = (LW > SZD_WL_W) ? LW : SZD_WL_W;
    localparam int IC_W   = (IB > LW + 1) ? IB : LW + 1;
    localparam int FC_W   = (SW > SZD_FLOOR_W) ? SW : SZD_FLOOR_W;

    localparam logic signed [Q_W-1:0] Q_MAX = {3'b000, {(SW-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {3'b111, {(SW-1){1'b0}}};

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ISSUE   = 6'b000010,
        ST_WAIT    = 6'b000100,
        ST_RD_PREV = 6'b001000,
        ST_WIN_RD  = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        OP_LX,      // L * x
        OP_DD,      // d * d
        OP_LEFT,    // d^2 * (L - 1)
        OP_LQ,      // L * Q
        OP_SS,      // S * S
        OP_VL,      // var * L
        OP_RIGHT,   // var * L * T
        OP_BX,      // w * x
        OP_BP,      // (1 - w) * prev
        OP_SQ       // window entry squared
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // control state
    logic [IB-1:0]           pos_reg;
    logic                    held_valid_reg;
    logic [AW-1:0]           wp_reg;
    logic [AW-1:0]           rp_reg;
    logic [LW-1:0]           cnt_reg;
    logic                    out_valid_reg;

    // held window
    logic signed [SUM_W-1:0] held_sum_reg;
    logic [SQ_W-1:0]         held_sq_reg;
    logic [LW-1:0]           held_len_reg;

    // per-sample working registers
    logic signed [SW-1:0]    x_reg;
    logic                    last_reg;
    logic [IB-1:0]           idx_reg;
    logic [LW-1:0]           lag_reg;
    logic signed [SUM_W-1:0] win_sum_reg;
    logic [SQ_W-1:0]         win_sq_reg;
    logic [SUM_W-1:0]        d_reg;
    logic [2*SUM_W-1:0]      dd_reg;
    logic [LF_W-1:0]         left_reg;
    logic [V_W-1:0]          var_reg;
    logic [VL_W-1:0]         vl_reg;
    logic signed [BL_W-1:0]  bl_reg;
    logic                    peak_reg;
    logic                    outlier_reg;
    logic signed [SW-1:0]    stored_reg;
    logic signed [SW-1:0]    rdata_reg;

    logic [IB-1:0]           out_index_reg;
    logic                    out_peak_reg;
    logic                    out_outlier_reg;
    logic                    out_last_reg;

    logic signed [SW-1:0]    hist_mem [HD];

    // combinational
    logic                    accept;
    logic                    out_free;
    logic                    mem_we;
    logic                    mem_re;
    logic [LW-1:0]           lag;
    logic                    lag_ok;
    logic [IC_W-1:0]         idx_e;
    logic [IC_W-1:0]         lag_e;
    logic                    judge;
    logic                    take;
    logic [SUM_W-1:0]        s_abs;
    logic [SW-1:0]           v_abs;
    logic [SZD_WGT_W-1:0]    w_clamp;
    logic [SZD_WGT_W-1:0]    w_comp;
    logic signed [SUM_W-1:0] lx;
    logic signed [SUM_W:0]   diff;
    logic [SUM_W-1:0]        d_new;
    logic                    outlier_new;
    logic signed [BL_W-1:0]  bl_sum;
    logic signed [Q_W-1:0]   q;
    logic signed [SW-1:0]    q_sat;
    logic signed [SUM_W-1:0] sum_new;
    logic [SQ_W-1:0]         sq_new;
    logic [AW-1:0]           wp_inc;
    logic [AW-1:0]           wp_dec;
    logic [AW-1:0]           rp_dec;

    logic                    mul_start;
    logic signed [PA-1:0]    mul_a;
    logic [PB-1:0]           mul_b;
    logic                    mul_done;
    logic signed [PW-1:0]    mul_p;

    szd_mul #(
        .PA  (PA),
        .PB  (PB),
        .DIG (SZD_MUL_DIG)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign mem_we    = (state_reg == ST_FINISH) && out_free;
    assign mem_re    = (state_reg == ST_RD_PREV) || (state_reg == ST_WIN_RD);
    assign mul_start = (state_reg == ST_ISSUE);

    assign wp_inc = (wp_reg == AW'(HD - 1)) ? '0 : wp_reg + AW'(1);
    assign wp_dec = (wp_reg == '0) ? AW'(HD - 1) : wp_reg - AW'(1);
    assign rp_dec = (rp_reg == '0) ? AW'(HD - 1) : rp_reg - AW'(1);

    // judge / window decision on the incoming sample
    always_comb
    begin
        if (LC_W'(cfg.window_length) > LC_W'(MAX_LAG))
            lag = LW'(MAX_LAG);
        else
            lag = LW'(cfg.window_length);
        lag_ok = (lag >= LW'(2));
        idx_e  = IC_W'(pos_reg);
        lag_e  = IC_W'(lag);
        judge  = lag_ok && (idx_e >= lag_e + IC_W'(1)) && held_valid_reg
                 && (FC_W'(in_sample) > FC_W'($signed(cfg.floor_level)))
                 && !((idx_e == lag_e + IC_W'(1)) && in_last);
        take   = lag_ok && (judge || ((idx_e >= lag_e) && !held_valid_reg));
    end

    // operand magnitudes and weights
    always_comb
    begin
        s_abs   = held_sum_reg[SUM_W-1] ? SUM_W'(~held_sum_reg) + SUM_W'(1)
                                        : SUM_W'(held_sum_reg);
        v_abs   = rdata_reg[SW-1] ? SW'(~rdata_reg) + SW'(1) : SW'(rdata_reg);
        w_clamp = (cfg.influence_weight > SZD_WGT_ONE) ? SZD_WGT_ONE
                                                       : cfg.influence_weight;
        w_comp  = SZD_WGT_ONE - w_clamp;
    end

    // shared unit operand select
    always_comb
    begin
        case (op_reg)
            OP_LX:
            begin
                mul_a = PA'(x_reg);
                mul_b = PB'(held_len_reg);
            end
            OP_DD:
            begin
                mul_a = PA'(d_reg);
                mul_b = PB'(d_reg);
            end
            OP_LEFT:
            begin
                mul_a = PA'(dd_reg);
                mul_b = PB'(held_len_reg - LW'(1));
            end
            OP_LQ:
            begin
                mul_a = PA'(held_sq_reg);
                mul_b = PB'(held_len_reg);
            end
            OP_SS:
            begin
                mul_a = PA'(s_abs);
                mul_b = PB'(s_abs);
            end
            OP_VL:
            begin
                mul_a = PA'(var_reg);
                mul_b = PB'(held_len_reg);
            end
            OP_RIGHT:
            begin
                mul_a = PA'(vl_reg);
                mul_b = PB'(cfg.threshold_squared);
            end
            OP_BX:
            begin
                mul_a = PA'(x_reg);
                mul_b = PB'(w_clamp);
            end
            OP_BP:
            begin
                mul_a = PA'(rdata_reg);
                mul_b = PB'(w_comp);
            end
            OP_SQ:
            begin
                mul_a = PA'(v_abs);
                mul_b = PB'(v_abs);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // result post-processing
    always_comb
    begin
        lx          = mul_p[SUM_W-1:0];
        diff        = {lx[SUM_W-1], lx} - {held_sum_reg[SUM_W-1], held_sum_reg};
        d_new       = diff[SUM_W] ? SUM_W'(~diff) + SUM_W'(1) : SUM_W'(diff);
        outlier_new = RT_W'(left_reg) > mul_p[RT_W-1:0];
        // round half up, then floor shift
        bl_sum      = bl_reg + mul_p[BL_W-1:0]
                      + BL_W'(1 << (SZD_WGT_FRAC - 1));
        q           = bl_sum[BL_W-1:SZD_WGT_FRAC];
        if (q > Q_MAX)
            q_sat = Q_MAX[SW-1:0];
        else if (q < Q_MIN)
            q_sat = Q_MIN[SW-1:0];
        else
            q_sat = q[SW-1:0];
        sum_new     = win_sum_reg + SUM_W'(rdata_reg);
        sq_new      = win_sq_reg + SQ_W'(mul_p[2*SW-1:0]);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (judge)
                    begin
                        state_next = ST_ISSUE;
                        op_next    = OP_LX;
                    end
                    else if (take)
                        state_next = ST_WIN_RD;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_ISSUE:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_LX:    op_next = OP_DD;
                        OP_DD:    op_next = OP_LEFT;
                        OP_LEFT:  op_next = OP_LQ;
                        OP_LQ:    op_next = OP_SS;
                        OP_SS:    op_next = OP_VL;
                        OP_VL:    op_next = OP_RIGHT;
                        OP_RIGHT: state_next = outlier_new ? ST_RD_PREV : ST_WIN_RD;
                        OP_BX:    op_next = OP_BP;
                        OP_BP:    state_next = ST_WIN_RD;
                        OP_SQ:    state_next = (cnt_reg == lag_reg) ? ST_FINISH
                                                                    : ST_WIN_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_PREV:
            begin
                state_next = ST_ISSUE;
                op_next    = OP_BX;
            end
            ST_WIN_RD:
            begin
                state_next = ST_ISSUE;
                op_next    = OP_SQ;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_LX;
            pos_reg        <= '0;
            held_valid_reg <= 1'b0;
            held_sum_reg   <= '0;
            held_sq_reg    <= '0;
            held_len_reg   <= '0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (accept)
            begin
                rp_reg  <= wp_dec;
                cnt_reg <= '0;
                if (in_last)
                begin
                    pos_reg        <= '0;
                    held_valid_reg <= 1'b0;
                end
                else
                begin
                    if (pos_reg != '1)
                        pos_reg <= pos_reg + IB'(1);
                    if (take)
                        held_valid_reg <= 1'b1;
                end
            end

            if (state_reg == ST_WIN_RD)
            begin
                rp_reg  <= rp_dec;
                cnt_reg <= cnt_reg + LW'(1);
            end

            // last window entry in: the window becomes the held one
            if ((state_reg == ST_WAIT) && mul_done && (op_reg == OP_SQ)
                && (cnt_reg == lag_reg))
            begin
                held_sum_reg <= sum_new;
                held_sq_reg  <= sq_new;
                held_len_reg <= lag_reg;
            end

            if (mem_we)
            begin
                wp_reg        <= wp_inc;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg       <= in_sample;
            last_reg    <= in_last;
            idx_reg     <= pos_reg;
            lag_reg     <= lag;
            stored_reg  <= in_sample;
            win_sum_reg <= '0;
            win_sq_reg  <= '0;
            peak_reg    <= 1'b0;
            outlier_reg <= 1'b0;
        end

        if ((state_reg == ST_WAIT) && mul_done)
        begin
            case (op_reg)
                OP_LX:
                begin
                    d_reg    <= d_new;
                    peak_reg <= !diff[SUM_W];
                end
                OP_DD:    dd_reg   <= mul_p[2*SUM_W-1:0];
                OP_LEFT:  left_reg <= LF_W'({mul_p[LF_W-SZD_THR_FRAC-1:0],
                                             {SZD_THR_FRAC{1'b0}}});
                OP_LQ:    var_reg  <= mul_p[V_W-1:0];
                OP_SS:    var_reg  <= var_reg - mul_p[V_W-1:0];
                OP_VL:    vl_reg   <= mul_p[VL_W-1:0];
                OP_RIGHT: outlier_reg <= outlier_new;
                OP_BX:    bl_reg   <= mul_p[BL_W-1:0];
                OP_BP:    stored_reg  <= q_sat;
                OP_SQ:
                begin
                    win_sum_reg <= sum_new;
                    win_sq_reg  <= sq_new;
                end
                default:  bl_reg   <= bl_reg;
            endcase
        end

        if (mem_we)
        begin
            out_index_reg   <= idx_reg;
            out_peak_reg    <= peak_reg && outlier_reg;
            out_outlier_reg <= outlier_reg;
            out_last_reg    <= last_reg;
        end
    end

    // history memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[wp_reg] <= stored_reg;
        if (mem_re)
            rdata_reg <= hist_mem[rp_reg];
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign out_peak    = out_peak_reg;
    assign out_outlier = out_outlier_reg;
    assign out_last    = out_last_reg;

endmodule

/* hw/rtl/smoothed_zscore_peak_detector.sv */
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detector : streaming smoothed z-score peak marker
// Configuration registers, stream port packing and the sample sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one signed correlation sample per word in s_tdata, s_tlast
//   marks the final sample of a record. Master stream: one result word per
//   sample: its record index in m_tdata, is_peak and is_outlier in m_tuser,
//   and m_tlast copies the record end mark.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 window
//   length, 1 squared threshold, 2 influence weight, 3 floor level); write
//   only while no sample is in flight.
//   Timing: one sample at a time, s_tready is high only while idle. Taking a
//   window of L samples costs one history read and one square on the shared
//   multiplier per entry. A judged sample adds seven products on the
//   two-digit shared multiplier, and an outlier a history read and two more
//   products for its blend.
//   The result sits in an output register and the next sample is taken while
//   it waits; under a receiver stall the following sample holds in its final
//   step until the register frees.
//   Reset: registers return to their defaults, the record index goes to zero
//   and no window is held. The history memory is not cleared.
// ----------------------------------------------------------------------------
module smoothed_zscore_peak_detector #(
    parameter int MAX_LAG     = szd_pkg::SZD_MAX_LAG,
    parameter int SAMPLE_BITS = szd_pkg::SZD_SAMPLE_BITS,
    parameter int INDEX_BITS  = szd_pkg::SZD_INDEX_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // slave stream
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]             s_tdata,  // sample
    input  logic                                         s_tlast,  // last_sample
    // master stream
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [((INDEX_BITS+7)/8)*8-1:0]              m_tdata,  // sample_index
    output logic [1:0]                                   m_tuser,  // [1] is_outlier, [0] is_peak
    output logic                                         m_tlast,  // record_end
    // configuration
    input  logic                                         cfg_we,
    input  logic [szd_pkg::SZD_CFG_IDX_W-1:0]            cfg_index,
    input  logic [szd_pkg::SZD_CFG_DATA_W-1:0]           cfg_data
);

    import szd_pkg::*;

    localparam int OUT_W = ((INDEX_BITS + 7) / 8) * 8;

    cfg_t                   cfg_reg;
    logic [INDEX_BITS-1:0]  res_index;
    logic                   res_peak;
    logic                   res_outlier;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length     <= SZD_WL_RST;
            cfg_reg.threshold_squared <= SZD_THR_RST;
            cfg_reg.influence_weight  <= SZD_WGT_RST;
            cfg_reg.floor_level       <= SZD_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e_t'(cfg_index))
                REG_WINDOW_LENGTH:
                    cfg_reg.window_length <= cfg_data[SZD_WL_W-1:0];
                REG_THRESHOLD_SQUARED:
                    cfg_reg.threshold_squared <= cfg_data[SZD_THR_W-1:0];
                REG_INFLUENCE_WEIGHT:
                    cfg_reg.influence_weight <= cfg_data[SZD_WGT_W-1:0];
                REG_FLOOR_LEVEL:
                    cfg_reg.floor_level <= cfg_data[SZD_FLOOR_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    szd_seq #(
        .MAX_LAG     (MAX_LAG),
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_last     (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (res_index),
        .out_peak    (res_peak),
        .out_outlier (res_outlier),
        .out_last    (m_tlast)
    );

    // pack result word, pad bits zero
    assign m_tdata = OUT_W'(res_index);
    assign m_tuser = {res_outlier, res_peak};

endmodule

/* test/zscore_peak_checker.sv */
// ----------------------------------------------------------------------------
// zscore_peak_checker : result predictor and comparator for the peak detector
// Watches the sample, result and register ports, predicts each result word
// from its own copy of the detector state and compares it field by field.
// ----------------------------------------------------------------------------
module zscore_peak_checker
    import szd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [15:0]               s_tdata,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [15:0]               m_tdata,
    input  logic [1:0]                m_tuser,
    input  logic                      m_tlast,
    input  logic                      cfg_we,
    input  logic [SZD_CFG_IDX_W-1:0]  cfg_index,
    input  logic [SZD_CFG_DATA_W-1:0] cfg_data,
    output int                        pending,
    output int                        fail_count
);

    localparam int HIST_DEPTH = SZD_MAX_LAG + 1;

    typedef struct packed {
        logic [15:0] sample_index;
        logic        is_peak;
        logic        is_outlier;
        logic        record_end;
    } peak_mark_t;

    // detector state copy
    logic signed [15:0]     hist [0:HIST_DEPTH-1];
    longint                 held_sum;
    longint                 held_sq;
    int unsigned            held_len;
    bit                     held_ok;
    logic [15:0]            rec_pos;
    int unsigned            wr_ptr;

    // register copy
    logic [SZD_WL_W-1:0]    wl;
    logic [SZD_THR_W-1:0]   thr;
    logic [SZD_WGT_W-1:0]   wgt;
    logic signed [15:0]     floor_lvl;

    peak_mark_t             due_marks [$];
    peak_mark_t             want;
    int                     errs;

    // sums of the len stored values just behind the write slot
    function automatic void capture_window(input int unsigned len);
        int unsigned slot;
        longint      v;
        held_sum = 0;
        held_sq  = 0;
        for (int unsigned k = 1; k <= len; k++)
        begin
            slot     = (wr_ptr + HIST_DEPTH - k) % HIST_DEPTH;
            v        = longint'(hist[slot]);
            held_sum += v;
            held_sq  += v * v;
        end
        held_len = len;
        held_ok  = 1'b1;
    endfunction

    function automatic peak_mark_t predict_mark(input logic signed [15:0] x,
                                                input logic lst);
        peak_mark_t          mark;
        int unsigned         lag;
        logic                judge;
        longint              lx, w, prev, blend, q;
        logic signed [127:0] len_w, dev_w, sum_w, sq_w, thr_w, lhs, rhs;
        logic signed [15:0]  keep;
        lag  = (wl > SZD_MAX_LAG) ? SZD_MAX_LAG : int'(wl);
        keep = x;
        mark = '0;
        mark.sample_index = rec_pos;
        mark.record_end   = lst;
        if (lag >= 2)
        begin
            judge = (rec_pos >= lag + 1) && held_ok && (x > floor_lvl) &&
                    !((rec_pos == lag + 1) && lst);
            if (judge)
            begin
                lx    = longint'(held_len) * longint'(x);
                len_w = 128'(held_len);
                dev_w = 128'(lx - held_sum);
                sum_w = 128'(held_sum);
                sq_w  = 128'(held_sq);
                thr_w = 128'(thr);
                // 256*(L-1)*(L*x-S)^2 against T*L*(L*Q-S^2), exact
                lhs = 256 * (len_w - 1) * dev_w * dev_w;
                rhs = thr_w * len_w * (len_w * sq_w - sum_w * sum_w);
                mark.is_outlier = (lhs > rhs);
                if (mark.is_outlier)
                begin
                    w     = (wgt > SZD_WGT_ONE) ? 65536 : longint'(wgt);
                    prev  = longint'(hist[(wr_ptr + HIST_DEPTH - 1) % HIST_DEPTH]);
                    blend = w * longint'(x) + (65536 - w) * prev + 32768;
                    q     = blend >>> 16;
                    if (q > 32767)
                        keep = 16'sh7fff;
                    else if (q < -32768)
                        keep = 16'sh8000;
                    else
                        keep = q[15:0];
                    mark.is_peak = (lx >= held_sum);
                end
                capture_window(lag);
            end
            else if (rec_pos >= lag && !held_ok)
            begin
                capture_window(lag);
            end
        end
        hist[wr_ptr] = keep;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (lst)
        begin
            rec_pos = '0;
            held_ok = 1'b0;
        end
        else if (rec_pos != 16'hffff)
        begin
            rec_pos = rec_pos + 16'd1;
        end
        return mark;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
                hist[k] = '0;
            held_sum  = 0;
            held_sq   = 0;
            held_len  = 0;
            held_ok   = 1'b0;
            rec_pos   = '0;
            wr_ptr    = 0;
            wl        = SZD_WL_RST;
            thr       = SZD_THR_RST;
            wgt       = SZD_WGT_RST;
            floor_lvl = SZD_FLOOR_RST;
            due_marks.delete();
            errs      = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH:     wl        = cfg_data[SZD_WL_W-1:0];
                    REG_THRESHOLD_SQUARED: thr       = cfg_data[SZD_THR_W-1:0];
                    REG_INFLUENCE_WEIGHT:  wgt       = cfg_data[SZD_WGT_W-1:0];
                    REG_FLOOR_LEVEL:       floor_lvl = cfg_data[SZD_FLOOR_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                due_marks.push_back(predict_mark(s_tdata, s_tlast));
            if (m_tvalid && m_tready)
            begin
                if (due_marks.size() == 0)
                begin
                    $error("unexpected result word: sample_index %0d", m_tdata);
                    errs++;
                end
                else
                begin
                    want = due_marks.pop_front();
                    if (m_tdata !== want.sample_index)
                    begin
                        $error("sample_index: expected %0d, got %0d",
                               want.sample_index, m_tdata);
                        errs++;
                    end
                    if (m_tuser[0] !== want.is_peak)
                    begin
                        $error("is_peak: expected %0b, got %0b", want.is_peak, m_tuser[0]);
                        errs++;
                    end
                    if (m_tuser[1] !== want.is_outlier)
                    begin
                        $error("is_outlier: expected %0b, got %0b",
                               want.is_outlier, m_tuser[1]);
                        errs++;
                    end
                    if (m_tlast !== want.record_end)
                    begin
                        $error("record_end: expected %0b, got %0b", want.record_end, m_tlast);
                        errs++;
                    end
                end
            end
            pending    <= due_marks.size();
            fail_count <= errs;
        end
    end

endmodule

/* test/smoothed_zscore_peak_detector_tb.sv */
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detector_tb : stimulus and verdict for the peak detector
// Drives a directed sequence and then random records of noisy baselines with
// spikes over many register settings. The checker beside the block predicts
// every result.
// ----------------------------------------------------------------------------
module smoothed_zscore_peak_detector_tb;

    import szd_pkg::*;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata   = '0;   // sample
    logic                      s_tlast   = 1'b0; // last_sample
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;          // sample_index
    logic [1:0]                m_tuser;          // [1] is_outlier, [0] is_peak
    logic                      m_tlast;          // record_end
    logic                      cfg_we    = 1'b0;
    logic [SZD_CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_LENGTH;
    logic [SZD_CFG_DATA_W-1:0] cfg_data  = '0;

    int pending;
    int fail_count;

    // when set, neither side inserts bubbles
    bit steady = 1'b0;

    // record generator state
    int rec_left  = 0;
    int base_lvl  = 0;
    int noise_amp = 0;
    int cur_lag   = 2;

    always #6 clk = ~clk;

    smoothed_zscore_peak_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    zscore_peak_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // receiver stalls at random about 8 percent of the time unless steady is set
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 8);

    // one word on the sample stream; valid is left high after the handshake
    // so back-to-back words never lower and raise it in the same step
    task automatic send_word(input logic [15:0] smp, input logic lst);
        while (!steady && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // writes all four registers on consecutive edges; junk above the window,
    // threshold and floor widths must be ignored
    task automatic load_settings(input logic [5:0] wl, input logic [15:0] thr,
                                 input logic [16:0] wgt, input logic [15:0] flr);
        int unsigned junk;
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= {junk[10:0], wl};
        @(posedge clk);
        cfg_index <= REG_THRESHOLD_SQUARED;
        cfg_data  <= {junk[11], thr};
        @(posedge clk);
        cfg_index <= REG_INFLUENCE_WEIGHT;
        cfg_data  <= wgt;
        @(posedge clk);
        cfg_index <= REG_FLOOR_LEVEL;
        cfg_data  <= {junk[12], flr};
        @(posedge clk);
        cfg_we    <= 1'b0;
        // lag used by the record generator; short windows still get records
        cur_lag = (wl > SZD_MAX_LAG) ? SZD_MAX_LAG : ((wl < 2) ? 2 : int'(wl));
    endtask

    // record lengths cluster just past the window so most samples get judged;
    // some are exactly window+2 and some too short to judge anything
    task automatic start_record;
        int r;
        int amps [4] = '{0, 40, 300, 2500};
        r = $urandom_range(0, 99);
        if (r < 15)
            rec_left = cur_lag + 2;
        else if (r < 30)
            rec_left = $urandom_range(1, cur_lag + 1);
        else
            rec_left = cur_lag + 3 + $urandom_range(0, 40);
        base_lvl  = int'($urandom_range(0, 16000)) - 2000;
        noise_amp = amps[$urandom_range(0, 3)];
    endtask

    function automatic logic [15:0] pick_sample;
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'($urandom);
        else if (r < 16)
            v = base_lvl + int'($urandom_range(1000, 30000));
        else if (r < 20)
            v = base_lvl - int'($urandom_range(1000, 30000));
        else
            v = base_lvl + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic feed_records(input int count);
        logic [15:0] smp;
        for (int n = 0; n < count; n++)
        begin
            if (rec_left == 0)
                start_record();
            smp = pick_sample();
            rec_left--;
            send_word(smp, rec_left == 0);
        end
    endtask

    // random register settings, weighted toward small windows
    task automatic load_random_settings;
        int          r;
        logic [5:0]  wl;
        logic [15:0] thr;
        logic [16:0] wgt;
        logic [15:0] flr;
        r = $urandom_range(0, 99);
        if (r < 10)
            wl = 6'($urandom_range(0, 1));
        else if (r < 16)
            wl = 6'($urandom_range(33, 63));
        else if (r < 22)
            wl = 6'd32;
        else
            wl = 6'($urandom_range(2, 12));
        r = $urandom_range(0, 99);
        if (r < 10)
            thr = 16'd0;
        else if (r < 20)
            thr = 16'hffff;
        else if (r < 70)
            thr = 16'($urandom_range(256, 6400));
        else
            thr = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            wgt = '0;
        else if (r < 20)
            wgt = SZD_WGT_ONE;
        else if (r < 30)
            wgt = 17'($urandom_range(65537, 131071));
        else
            wgt = 17'($urandom_range(0, 65536));
        r = $urandom_range(0, 99);
        if (r < 10)
            flr = 16'h8000;
        else if (r < 15)
            flr = 16'h7fff;
        else if (r < 25)
            flr = 16'($urandom);
        else
            flr = 16'($urandom_range(0, 6000) - 3000);
        load_settings(wl, thr, wgt, flr);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: window of two, unit z threshold, full weight, floor at zero
        load_settings(6'd2, 16'd256, SZD_WGT_ONE, 16'd0);
        // record of window+2 ending on the first judgeable index
        send_word(16'd1000, 1'b0);
        send_word(16'd1000, 1'b0);
        send_word(16'd1000, 1'b0);
        send_word(16'd5000, 1'b1);
        // field extremes, samples at and below the floor, a flat window
        // followed by a spike and a dip above the floor
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h7fff, 1'b0);
        send_word(16'd2000, 1'b0);
        send_word(16'd2000, 1'b0);
        send_word(16'd2000, 1'b0);
        send_word(16'd2000, 1'b0);
        send_word(16'h7fff, 1'b0);
        send_word(16'd100,  1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'd2000, 1'b0);
        send_word(16'd2000, 1'b1);
        drain();
        // window below two judges nothing
        load_settings(6'd1, 16'd4800, 17'd3277, 16'd6636);
        send_word(16'd7000, 1'b0);
        send_word(16'd9000, 1'b0);
        send_word(16'd30000, 1'b1);
        drain();

        // random phases; settings change between phases, often mid-record
        for (int ph = 0; ph < 24; ph++)
        begin
            steady = (ph >= 9 && ph < 12);
            case (ph)
                0: load_settings(6'd63, 16'hffff, 17'h1ffff, 16'h8000);
                1: load_settings(6'd0, 16'd0, 17'd0, 16'h7fff);
                2: load_settings(6'd32, 16'd0, SZD_WGT_ONE, 16'h8000);
                3: load_settings(6'd2, 16'd0, 17'd65535, 16'h8000);
                default: load_random_settings();
            endcase
            feed_records(80);
            drain();
        end

        // extreme swings at a window of two, half weight, record closed
        steady = 1'b0;
        load_settings(6'd2, 16'd0, 17'd32768, 16'h8000);
        send_word(16'd500, 1'b0);
        send_word(16'd700, 1'b0);
        send_word(16'd600, 1'b0);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8001, 1'b0);
        send_word(16'd650, 1'b1);
        drain();
        rec_left = 0;

        // let any stray result word show up before the verdict
        repeat (250) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, several times the slowest correct run
    initial
    begin
        #(64'd60_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
